### hdl/emdl_pkg.sv
// ----------------------------------------------------------------------------
// emdl_pkg: shared types and constants of the multitap echo delay line
// Register indexes, reset values and the control bundles that pass between
// the configuration block, the history sequencer and the multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none

package emdl_pkg;

  // Field widths fixed by the register layout.
  localparam int GAIN_W     = 16;
  localparam int DELAY_W    = 12;
  localparam int TAP_W      = 28;
  localparam int TAP_CNT_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int FRAC_BITS  = 15;

  // Number of tap registers and the index width that selects one of them.
  localparam int TAP_REGS   = 4;
  localparam int TAP_IDX_W  = 2;

  // Reduced delays are carried at the width of the deepest history.
  localparam int DM_W       = 16;

  // Guard bits of the accumulator: the dry term plus up to four taps.
  localparam int ACC_GUARD  = 3;

  // Result queue depth, which also bounds the requests in flight.
  localparam int OUT_PTR_W  = 2;
  localparam int OUT_CNT_W  = 3;
  localparam logic [OUT_CNT_W-1:0] OUT_DEPTH = 3'd4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TAPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP0        = 3'd2;

  // Reset values.
  localparam logic [GAIN_W-1:0]    DRY_GAIN_RST    = 16'h4000;
  localparam logic [TAP_CNT_W-1:0] ACTIVE_TAPS_RST = 3'd4;
  localparam logic [TAP_W-1:0]     TAP_RST [TAP_REGS] = '{
    28'd33555456, 28'd16778752, 28'd8391168, 28'd8391680
  };

  // One tap as the sequencer sees it: delay already reduced modulo depth.
  typedef struct packed {
    logic [DM_W-1:0]   dm;
    logic [GAIN_W-1:0] gain;
  } tap_cfg_t;

  // Configuration bundle from the register block.
  typedef struct packed {
    logic [GAIN_W-1:0]               dry_gain;
    logic [TAP_CNT_W-1:0]            n_taps;
    tap_cfg_t [TAP_REGS-1:0]         taps;
  } cfg_bus_t;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic              vld;
    logic              first;
    logic              last;
    logic [GAIN_W-1:0] gain;
  } mac_ctl_t;

endpackage

`default_nettype wire

### hdl/emdl_cfg.sv
// ----------------------------------------------------------------------------
// emdl_cfg: configuration registers
// Holds the dry gain, the tap count and the tap registers, and keeps each
// tap delay reduced modulo the history depth, updated in the cycle after it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module emdl_cfg
  import emdl_pkg::*;
#(
  parameter int DELAY_DEPTH = 4096,
  parameter int MAX_TAPS    = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_bus_t                   cfg_bus
);

  // Reciprocal of the depth, rounded up; exact quotient for 12-bit delays.
  localparam int RECIP_SH = 24;
  localparam logic [RECIP_SH-1:0] RECIP =
    RECIP_SH'(((64'd1 << RECIP_SH) + 64'(DELAY_DEPTH) - 64'd1) / 64'(DELAY_DEPTH));
  localparam logic [31:0] DEPTH_W32 = 32'(DELAY_DEPTH);

  // Taps beyond the implemented count are never sequenced.
  localparam int N_LIM_I = (MAX_TAPS < TAP_REGS) ? MAX_TAPS : TAP_REGS;
  localparam logic [TAP_CNT_W-1:0] N_LIM = TAP_CNT_W'(N_LIM_I);

  logic [GAIN_W-1:0]    dry_r;
  logic [TAP_CNT_W-1:0] act_r;
  logic [RECIP_SH+DELAY_W-1:0] q_prod;
  logic [DELAY_W-1:0]   q_wr;

  // Quotient of the delay being written, stored with the tap.
  assign q_prod = (RECIP_SH+DELAY_W)'(cfg_wdata[DELAY_W-1:0]) *
                  (RECIP_SH+DELAY_W)'(RECIP);
  assign q_wr   = q_prod[RECIP_SH+DELAY_W-1:RECIP_SH];

  // Dry gain and tap count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_r <= DRY_GAIN_RST;
      act_r <= ACTIVE_TAPS_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_DRY_GAIN) begin
        dry_r <= cfg_wdata[GAIN_W-1:0];
      end
      if (cfg_index == REG_ACTIVE_TAPS) begin
        act_r <= cfg_wdata[TAP_CNT_W-1:0];
      end
    end
  end

  assign cfg_bus.dry_gain = dry_r;
  assign cfg_bus.n_taps   = (act_r > N_LIM) ? N_LIM : act_r;

  // Per-tap register, quotient and reduced delay.
  for (genvar t = 0; t < TAP_REGS; t++) begin : g_tap
    localparam logic [DELAY_W-1:0] D_RST  = TAP_RST[t][DELAY_W-1:0];
    localparam logic [DELAY_W-1:0] Q_RST  = DELAY_W'(32'(D_RST) / DEPTH_W32);
    localparam logic [DM_W-1:0]    DM_RST = DM_W'(32'(D_RST) % DEPTH_W32);

    logic [TAP_W-1:0]   tap_r;
    logic [DELAY_W-1:0] q_r;
    logic [DM_W-1:0]    dm_r;
    logic [31:0]        dm_nxt;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tap_r <= TAP_RST[t];
        q_r   <= Q_RST;
      end else if (cfg_wr_en && (cfg_index == REG_TAP0 + CFG_IDX_W'(t))) begin
        tap_r <= cfg_wdata;
        q_r   <= q_wr;
      end
    end

    // The remainder follows the stored quotient in the next cycle.
    assign dm_nxt = 32'(tap_r[DELAY_W-1:0]) - 32'(q_r) * DEPTH_W32;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dm_r <= DM_RST;
      end else begin
        dm_r <= dm_nxt[DM_W-1:0];
      end
    end

    assign cfg_bus.taps[t].dm   = dm_r;
    assign cfg_bus.taps[t].gain = tap_r[TAP_W-1:DELAY_W];
  end

endmodule

`default_nettype wire

### hdl/emdl_hist.sv
// ----------------------------------------------------------------------------
// emdl_hist: history memory and access sequencer
// Each request takes one memory slot to write its sample and one slot per
// active tap to read a delayed sample; operands go on to the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module emdl_hist
  import emdl_pkg::*;
#(
  parameter int DELAY_DEPTH = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  cfg_bus_t                    cfg_bus,
  input  wire logic                   start,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  output logic                        seq_free,
  output mac_ctl_t                    mac_ctl,
  output logic [SAMPLE_BITS-1:0]      mac_operand
);

  localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam logic [AW-1:0] WP_LAST  = AW'(DELAY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DELAY_DEPTH);

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  logic                   busy_r;
  logic [TAP_CNT_W-1:0]   slot_r;
  logic [TAP_CNT_W-1:0]   n_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [AW-1:0]          cur_wp_r;
  logic                   cur_full_r;
  logic [AW-1:0]          wp_r;
  logic                   full_r;

  logic                   last_slot;
  logic [TAP_IDX_W-1:0]   tsel;
  logic [AW-1:0]          dm;
  logic [AW:0]            diff;
  logic [AW:0]            diff_wrap;
  logic [AW-1:0]          rp;
  logic                   rd_ok;
  logic                   we;
  logic [AW-1:0]          addr;

  logic                   s1_vld_r;
  logic                   s1_first_r;
  logic                   s1_last_r;
  logic                   s1_ok_r;
  logic [GAIN_W-1:0]      s1_gain_r;
  logic [SAMPLE_BITS-1:0] s1_x_r;
  logic [SAMPLE_BITS-1:0] rdata_r;

  assign last_slot = (slot_r == n_r);
  assign seq_free  = !busy_r || last_slot;

  // Sequencer control: slot zero writes, slots one to n read the taps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
      wp_r   <= '0;
      full_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      slot_r <= '0;
      wp_r   <= (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
      if (wp_r == WP_LAST) begin
        full_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (last_slot) begin
        busy_r <= 1'b0;
      end else begin
        slot_r <= slot_r + TAP_CNT_W'(1);
      end
    end
  end

  // Request payload held for the length of its slots.
  always_ff @(posedge clk) begin
    if (start) begin
      n_r        <= cfg_bus.n_taps;
      x_r        <= sample;
      cur_wp_r   <= wp_r;
      cur_full_r <= full_r;
    end
  end

  // Read position of the current tap, wrapped into the history.
  assign tsel      = TAP_IDX_W'(slot_r - TAP_CNT_W'(1));
  assign dm        = cfg_bus.taps[tsel].dm[AW-1:0];
  assign diff      = {1'b0, cur_wp_r} - {1'b0, dm};
  assign diff_wrap = diff + DEPTH_X;
  assign rp        = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

  // Entries above the write position are unwritten until the first wrap.
  assign rd_ok = cur_full_r || (rp <= cur_wp_r);

  assign we   = busy_r && (slot_r == '0);
  assign addr = (slot_r == '0) ? cur_wp_r : rp;

  // Single-port history memory.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= x_r;
    end
    rdata_r <= mem[addr];
  end

  // Issue stage aligned with the memory read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (slot_r == '0);
    s1_last_r  <= last_slot;
    s1_ok_r    <= rd_ok;
    s1_gain_r  <= (slot_r == '0) ? cfg_bus.dry_gain : cfg_bus.taps[tsel].gain;
    s1_x_r     <= x_r;
  end

  assign mac_ctl.vld   = s1_vld_r;
  assign mac_ctl.first = s1_first_r;
  assign mac_ctl.last  = s1_last_r;
  assign mac_ctl.gain  = s1_gain_r;
  assign mac_operand   = s1_first_r ? s1_x_r : (s1_ok_r ? rdata_r : '0);

endmodule

`default_nettype wire

### hdl/emdl_mac.sv
// ----------------------------------------------------------------------------
// emdl_mac: multiply-accumulate and output scaling
// Multiplies each operand by its gain, sums the terms of one request and
// turns the sum into a saturated sample after a Q1.15 shift.
// ----------------------------------------------------------------------------
`default_nettype none

module emdl_mac
  import emdl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  mac_ctl_t                    mac_ctl,
  input  wire logic [SAMPLE_BITS-1:0] mac_operand,
  output logic                        res_vld,
  output logic [SAMPLE_BITS-1:0]      res_data
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int ACC_W  = PROD_W + ACC_GUARD;
  localparam int SH_W   = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic                     c2_vld_r;
  logic                     c2_first_r;
  logic                     c2_last_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     done_r;
  logic signed [SH_W-1:0]   shifted;
  logic [SH_W-SAMPLE_BITS:0] sh_hi;
  logic                     pos_ovf;
  logic                     neg_ovf;

  // Product stage.
  assign prod = $signed(mac_operand) * $signed(mac_ctl.gain);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_vld_r <= 1'b0;
    end else begin
      c2_vld_r <= mac_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod;
    c2_first_r <= mac_ctl.first;
    c2_last_r  <= mac_ctl.last;
  end

  // Accumulate stage: the dry term restarts the sum.
  assign prod_ext = ACC_W'(prod_r);
  assign acc_nxt  = c2_first_r ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= c2_vld_r && c2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c2_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Arithmetic shift rounds toward minus infinity; then saturate.
  assign shifted = SH_W'(acc_r >>> FRAC_BITS);
  assign sh_hi   = shifted[SH_W-1:SAMPLE_BITS-1];
  assign pos_ovf = !shifted[SH_W-1] && (|sh_hi);
  assign neg_ovf = shifted[SH_W-1] && !(&sh_hi);

  always_comb begin
    priority if (pos_ovf) begin
      res_data = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (neg_ovf) begin
      res_data = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res_data = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign res_vld = done_r;

endmodule

`default_nettype wire

### hdl/emdl_ofifo.sv
// ----------------------------------------------------------------------------
// emdl_ofifo: result queue and request credit
// Buffers finished results for the output channel and counts requests in
// flight so that every accepted request has a queue entry waiting for it.
// ----------------------------------------------------------------------------
`default_nettype none

module emdl_ofifo
  import emdl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   take,
  input  wire logic                   push,
  input  wire logic [SAMPLE_BITS-1:0] push_data,
  output logic                        credit_ok,
  output logic                        pop_vld,
  input  wire logic                   pop_rdy,
  output logic [SAMPLE_BITS-1:0]      pop_data
);

  logic [SAMPLE_BITS-1:0] q_mem [int'(OUT_DEPTH)];
  logic [OUT_PTR_W-1:0]   wr_ptr_r;
  logic [OUT_PTR_W-1:0]   rd_ptr_r;
  logic [OUT_CNT_W-1:0]   fill_r;
  logic [OUT_CNT_W-1:0]   credit_r;
  logic                   pop;

  assign pop       = pop_vld && pop_rdy;
  assign pop_vld   = (fill_r != '0);
  assign pop_data  = q_mem[rd_ptr_r];
  assign credit_ok = (credit_r < OUT_DEPTH);

  // Pointers, fill level and requests in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      credit_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
      fill_r   <= fill_r + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
      credit_r <= credit_r + OUT_CNT_W'(take) - OUT_CNT_W'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/multitap_echo_delay_line_top.sv
// Schedule: each request takes one history slot for its write and one per active tap to read,
// set by the single history port; the next request can be accepted in the last slot of the
// one before. With no taps the four-entry result queue bounds how many requests are taken.
// At most four requests are in flight.
// Reset: synchronous, active low; registers take their reset values at once, and history
// entries read as zero until written, tracked by the write position, with no clearing pass.
// ----------------------------------------------------------------------------
// multitap_echo_delay_line_top: multitap echo delay line
// Writes each sample into a circular history and outputs the dry term plus
// the gained, delayed samples of the active taps, scaled and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_echo_delay_line_top
  import emdl_pkg::*;
#(
  parameter int DELAY_DEPTH = 4096,
  parameter int MAX_TAPS    = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel; in_tdata: sample_in
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  // Result channel; out_tdata: echo_out
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         out_tdata,
  // Configuration write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]                cfg_index,
  input  wire logic [CFG_DATA_W-1:0]               cfg_wdata
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cfg_bus_t               cfg_bus;
  mac_ctl_t               mac_ctl;
  logic [SAMPLE_BITS-1:0] mac_operand;
  logic                   seq_free;
  logic                   credit_ok;
  logic                   accept;
  logic                   res_vld;
  logic [SAMPLE_BITS-1:0] res_data;
  logic [SAMPLE_BITS-1:0] q_data;

  // A request enters when the memory schedule frees and a queue entry is reserved.
  assign in_tready = seq_free && credit_ok;
  assign accept    = in_tvalid && in_tready;

  emdl_cfg #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .MAX_TAPS    (MAX_TAPS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_bus   (cfg_bus)
  );

  emdl_hist #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hist (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_bus     (cfg_bus),
    .start       (accept),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .seq_free    (seq_free),
    .mac_ctl     (mac_ctl),
    .mac_operand (mac_operand)
  );

  emdl_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .mac_ctl     (mac_ctl),
    .mac_operand (mac_operand),
    .res_vld     (res_vld),
    .res_data    (res_data)
  );

  emdl_ofifo #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (accept),
    .push      (res_vld),
    .push_data (res_data),
    .credit_ok (credit_ok),
    .pop_vld   (out_tvalid),
    .pop_rdy   (out_tready),
    .pop_data  (q_data)
  );

  assign out_tdata = DATA_W'(q_data);

endmodule

`default_nettype wire

### bench/multitap_echo_delay_line_top_tb.sv
// ----------------------------------------------------------------------------
// multitap_echo_delay_line_top_tb: self-checking bench of the echo delay line
// Streams audio samples into the block under a range of register settings and
// compares every echo result against a bit-exact predictor of the history,
// the tap sums, the Q1.15 scaling and the output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module multitap_echo_delay_line_top_tb;
  import emdl_pkg::*;

  localparam int SAMPLE_W    = 24;
  localparam int HIST_DEPTH  = 4096;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS  = 40;

  // Indexes past the last tap register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SAMPLE_W-1:0]   out_tdata;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Predictor state: sample history, write pointer and register copies.
  logic signed [SAMPLE_W-1:0] hist [HIST_DEPTH];
  logic [DELAY_W-1:0]         wr_pos;
  logic signed [GAIN_W-1:0]   m_dry;
  logic [TAP_CNT_W-1:0]       m_taps;
  logic [TAP_W-1:0]           m_tap [TAP_REGS];

  logic [SAMPLE_W-1:0] expected_echo [$];
  int                  mismatch_count = 0;
  bit                  send_idle_en   = 1'b1;
  bit                  recv_idle_en   = 1'b1;
  int                  hold_off       = 0;

  multitap_echo_delay_line_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // sample_in
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // echo_out
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Print one line per mismatch, up to a cap, and count them all.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // Write the sample into the history and form the saturated echo sum.
  task automatic predict_echo(input logic signed [SAMPLE_W-1:0] x,
                              output logic [SAMPLE_W-1:0] echo);
    longint             acc;
    longint             r;
    int                 n;
    logic [DELAY_W-1:0] rd_pos;
    hist[wr_pos] = x;
    acc = longint'(x) * longint'(m_dry);
    n = (m_taps > TAP_REGS) ? TAP_REGS : int'(m_taps);
    for (int t = 0; t < n; t++) begin
      rd_pos = wr_pos - m_tap[t][DELAY_W-1:0];
      acc += longint'($signed(m_tap[t][TAP_W-1:DELAY_W])) * longint'(hist[rd_pos]);
    end
    wr_pos = wr_pos + 1'b1;
    // Arithmetic shift rounds toward minus infinity.
    r = acc >>> FRAC_BITS;
    if (r > longint'(SAMPLE_MAX)) r = longint'(SAMPLE_MAX);
    if (r < longint'(SAMPLE_MIN)) r = longint'(SAMPLE_MIN);
    echo = r[SAMPLE_W-1:0];
  endtask

  // Offer one sample request after a random gap and predict its echo once taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample);
    int                  gap;
    logic [SAMPLE_W-1:0] echo;
    gap = send_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_echo(sample, echo);
    expected_echo.push_back(echo);
  endtask

  // Drive one register write and mirror it into the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_DRY_GAIN:    m_dry  = data[GAIN_W-1:0];
      REG_ACTIVE_TAPS: m_taps = data[TAP_CNT_W-1:0];
      default: begin
        if (idx >= REG_TAP0 && idx < REG_TAP0 + TAP_REGS) begin
          m_tap[int'(idx - REG_TAP0)] = data[TAP_W-1:0];
        end
      end
    endcase
  endtask

  // Close a group of register writes.
  task automatic finish_writes();
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering samples and wait until every predicted echo has arrived.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_echo.size() != 0) @(posedge clk);
  endtask

  // Gain mix: half moderate so sums stay in range, else full-range random or full scale.
  function automatic logic [GAIN_W-1:0] rand_gain();
    int g;
    case ($urandom_range(0, 5))
      0, 1:    g = $urandom_range(0, 65535);
      5:       g = $urandom_range(0, 1) ? 32767 : -32768;
      default: g = int'($urandom_range(0, 8191)) - 4096;
    endcase
    return g[GAIN_W-1:0];
  endfunction

  // Delay mix: short, within the written history, or anywhere in 12 bits.
  function automatic logic [DELAY_W-1:0] rand_delay();
    int d;
    case ($urandom_range(0, 3))
      0:       d = $urandom_range(0, 7);
      1:       d = $urandom_range(0, 63);
      2:       d = $urandom_range(0, int'(wr_pos));
      default: d = $urandom_range(0, HIST_DEPTH - 1);
    endcase
    return d[DELAY_W-1:0];
  endfunction

  // Sample mix: full-range noise, small values and the two limits.
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [31:0] w;
    int          s;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: begin
        s = int'($urandom_range(0, 4095)) - 2048;
        return s[SAMPLE_W-1:0];
      end
      default: return w[SAMPLE_W-1:0];
    endcase
  endfunction

  // Program every register with a random setting; stray bits ride along above the fields.
  task automatic program_random_config();
    logic [31:0] w;
    w = $urandom;
    w[GAIN_W-1:0] = rand_gain();
    write_reg(REG_DRY_GAIN, w[CFG_DATA_W-1:0]);
    w = $urandom;
    w[TAP_CNT_W-1:0] = TAP_CNT_W'($urandom_range(0, 7));
    write_reg(REG_ACTIVE_TAPS, w[CFG_DATA_W-1:0]);
    for (int t = 0; t < TAP_REGS; t++) begin
      w = $urandom;
      w[TAP_W-1:DELAY_W] = rand_gain();
      w[DELAY_W-1:0]     = rand_delay();
      write_reg(REG_TAP0 + CFG_IDX_W'(t), w[CFG_DATA_W-1:0]);
    end
    if ($urandom_range(0, 2) == 0) begin
      w = $urandom;
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, w[CFG_DATA_W-1:0]);
    end
    finish_writes();
  endtask

  // Reset settings: long delays reach unwritten entries, which read as zero.
  task automatic test_reset_taps();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    send_sample({SAMPLE_W{1'b1}});
    send_sample(24'd1);
    send_sample(24'h5A5A5A);
    wait_drained();
  endtask

  // Zero delay, full-scale gains, saturation, tap counts past the limit, spare indexes.
  task automatic test_special_cases();
    logic [31:0] w;
    write_reg(REG_DRY_GAIN, 28'h0007FFF);
    write_reg(REG_ACTIVE_TAPS, 28'd4);
    write_reg(REG_TAP0,        {16'h7FFF, 12'd0});
    write_reg(REG_TAP0 + 3'd1, {16'h8000, 12'd1});
    write_reg(REG_TAP0 + 3'd2, 28'hFFFFFFF);
    write_reg(REG_TAP0 + 3'd3, 28'h0000000);
    finish_writes();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample('0);
    wait_drained();

    // Dry path alone with the most negative gain.
    write_reg(REG_ACTIVE_TAPS, 28'd0);
    write_reg(REG_DRY_GAIN, 28'hFFF8000);
    finish_writes();
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(24'd1);
    wait_drained();

    // Tap counts above the limit act as four; spare indexes change nothing.
    write_reg(REG_ACTIVE_TAPS, 28'd7);
    w = $urandom;
    write_reg(REG_SPARE_LO, w[CFG_DATA_W-1:0]);
    w = $urandom;
    write_reg(REG_SPARE_HI, w[CFG_DATA_W-1:0]);
    finish_writes();
    repeat (3) send_sample(rand_sample());
    wait_drained();
    write_reg(REG_ACTIVE_TAPS, 28'd5);
    finish_writes();
    send_sample(rand_sample());
    wait_drained();
    write_reg(REG_ACTIVE_TAPS, 28'd6);
    finish_writes();
    send_sample(rand_sample());
    wait_drained();
  endtask

  // Random samples under a series of random settings.
  task automatic test_random_settings();
    for (int phase = 0; phase < 5; phase++) begin
      program_random_config();
      repeat (60) send_sample(rand_sample());
      wait_drained();
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_input_stall();
    send_idle_en = 1'b0;
    hold_off = HOLD_CYCLES;
    repeat (16) send_sample(rand_sample());
    wait_drained();
    send_idle_en = 1'b1;
  endtask

  // Long and short delays at full rate; the longer ones reach back to the first samples or to unwritten entries.
  task automatic test_long_delays();
    write_reg(REG_ACTIVE_TAPS, 28'd4);
    write_reg(REG_TAP0,        {16'h2000, 12'd300});
    write_reg(REG_TAP0 + 3'd1, {16'hE000, 12'd333});
    write_reg(REG_TAP0 + 3'd2, {16'h1000, 12'd2048});
    write_reg(REG_TAP0 + 3'd3, {16'h0800, 12'd1});
    finish_writes();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    repeat (120) send_sample(rand_sample());
    wait_drained();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // Result side: random stalls, an optional long hold-off, and the comparison.
  initial begin : result_checker
    int                  gap;
    logic [SAMPLE_W-1:0] want;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off > 0) begin
        gap = hold_off;
        hold_off = 0;
      end else begin
        gap = recv_idle_en ? $urandom_range(0, 11) : 0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (expected_echo.size() == 0) begin
        report_mismatch($sformatf("echo_out %h with no request outstanding", out_tdata));
      end else begin
        want = expected_echo.pop_front();
        if (out_tdata !== want) begin
          report_mismatch($sformatf("echo_out %h, predicted %h", out_tdata, want));
        end
      end
    end
  end

  // End the run when nothing moves on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) hist[i] = '0;
    wr_pos = '0;
    m_dry  = DRY_GAIN_RST;
    m_taps = ACTIVE_TAPS_RST;
    for (int t = 0; t < TAP_REGS; t++) m_tap[t] = TAP_RST[t];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_taps();
    test_special_cases();
    test_random_settings();
    test_input_stall();
    test_long_delays();

    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
